// File: hdl/lmi_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the LMI link integrity monitor.
// Used by lmi_link_check, lmi_event_core and lmi_link_integrity_monitor.
package lmi_pkg;

    localparam int HISTORY_BITS_DEF = 16;

    localparam int SEQ_W   = 8;
    localparam int RPT_W   = 8;
    localparam int POLL_W  = 8;
    localparam int WIN_W   = 5;
    localparam int ERR_W   = 16;
    localparam int AWAIT_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic       ROLE_USER    = 1'b0;
    localparam logic       ROLE_NETWORK = 1'b1;

    localparam logic [RPT_W-1:0] RPT_FULL = 8'h00;
    localparam logic [RPT_W-1:0] RPT_LINK = 8'h01;

    localparam logic              ROLE_RST     = ROLE_USER;
    localparam logic [POLL_W-1:0] FULL_INT_RST = 8'd6;
    localparam logic [WIN_W-1:0]  THRESH_RST   = 5'd3;
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLE      = 2'd0,
        CFG_FULL_INT  = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_WINDOW    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_POLL     = 2'd0,
        MODE_TIMEOUT  = 2'd1,
        MODE_ENQUIRY  = 2'd2,
        MODE_STATUS   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SEQ_IGNORED = 3'd1,
        ST_WRONG_ROLE  = 3'd2,
        ST_MISSING     = 3'd3,
        ST_BAD_REPORT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ENQUIRY = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              role;
        logic [POLL_W-1:0] full_poll_interval;
        logic [WIN_W-1:0]  error_threshold;
        logic [WIN_W-1:0]  window_events;
    } cfg_t;

    typedef struct packed {
        mode_t            mode;
        logic             report_present;
        logic             verif_present;
        logic [RPT_W-1:0] report_type;
        logic [SEQ_W-1:0] rx_send_seq;
        logic [SEQ_W-1:0] rx_recv_seq;
    } evt_t;

    typedef struct packed {
        status_t          status;
        kind_t            send_kind;
        logic [RPT_W-1:0] tx_report_type;
        logic             tx_has_verif;
        logic [SEQ_W-1:0] tx_send_seq;
        logic [SEQ_W-1:0] tx_recv_seq;
        logic             link_up;
        logic [ERR_W-1:0] error_total;
    } res_t;

endpackage

// File: hdl/lmi_link_check.sv
`timescale 1ns / 1ps
// Link health decision: counts good events in the recent window of the
// event history and compares the failures with the threshold. Uses lmi_pkg.
module lmi_link_check #(
    parameter int HISTORY_BITS = lmi_pkg::HISTORY_BITS_DEF
) (
    input  logic [HISTORY_BITS-1:0]   history,
    input  logic [lmi_pkg::WIN_W-1:0] window_events,
    input  logic [lmi_pkg::WIN_W-1:0] error_threshold,
    output logic                      reliable
);

    localparam int CW    = $clog2(HISTORY_BITS + 1);
    localparam int CMP_W = (CW > lmi_pkg::WIN_W) ? CW : lmi_pkg::WIN_W;

    logic [CMP_W-1:0] win_ext;
    logic [CMP_W-1:0] win_used;
    logic [CMP_W-1:0] ones;
    logic [CMP_W-1:0] fails;

    always_comb begin
        win_ext = CMP_W'(window_events);
        if (win_ext > CMP_W'(HISTORY_BITS)) begin
            win_used = CMP_W'(HISTORY_BITS);
        end else begin
            win_used = win_ext;
        end
        ones = '0;
        for (int i = 0; i < HISTORY_BITS; i++) begin
            if (CMP_W'(i) < win_used) begin
                ones = ones + CMP_W'(history[i]);
            end
        end
        fails    = win_used - ones;
        reliable = !(fails >= CMP_W'(error_threshold));
    end

endmodule

// File: hdl/lmi_event_core.sv
`timescale 1ns / 1ps
// Protocol state and per-event decision logic for the LMI monitor.
// Uses lmi_pkg and lmi_link_check.
module lmi_event_core #(
    parameter int HISTORY_BITS = lmi_pkg::HISTORY_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lmi_pkg::cfg_t cfg,
    input  lmi_pkg::evt_t evt,
    input  logic          fire,
    input  logic          reload,
    output logic          busy,
    output lmi_pkg::res_t res
);

    localparam int BIT_W = $clog2(lmi_pkg::POLL_W);

    logic [lmi_pkg::SEQ_W-1:0]   own_seq_reg, own_seq_next;
    logic [lmi_pkg::SEQ_W-1:0]   peer_seq_reg, peer_seq_next;
    logic [HISTORY_BITS-1:0]     hist_reg, hist_next;
    logic                        link_reg, link_next;
    logic [lmi_pkg::ERR_W-1:0]   err_reg, err_next;
    logic [lmi_pkg::POLL_W-1:0]  poll_reg, poll_next;
    logic [lmi_pkg::AWAIT_W-1:0] await_reg, await_next;
    logic [lmi_pkg::POLL_W-1:0]  phase_reg, phase_next;
    logic                        busy_reg;
    logic [BIT_W-1:0]            bit_reg;
    logic [lmi_pkg::POLL_W-1:0]  rem_reg;

    logic [lmi_pkg::SEQ_W-1:0]  seq_inc;
    logic [lmi_pkg::ERR_W-1:0]  err_inc;
    logic [lmi_pkg::POLL_W-1:0] poll_div;
    logic [lmi_pkg::POLL_W-1:0] phase_inc;
    logic [lmi_pkg::POLL_W:0]   rem_shift;
    logic [lmi_pkg::POLL_W:0]   rem_sub;
    logic [lmi_pkg::POLL_W-1:0] rem_step;
    logic [HISTORY_BITS:0]      hist_wide;
    logic [HISTORY_BITS-1:0]    hist_shift;
    logic                       rec_en;
    logic                       rec_good;
    logic                       bump;
    logic                       rel_new;

    assign seq_inc  = (own_seq_reg == 8'hFF) ? 8'h01 : own_seq_reg + 8'h01;
    assign err_inc  = (err_reg == '1) ? err_reg : err_reg + 16'h0001;
    assign poll_div = (cfg.full_poll_interval == '0) ? 8'h01 : cfg.full_poll_interval;

    // The poll phase tracks the poll counter modulo the interval and
    // returns to zero when the counter wraps.
    assign phase_inc = (poll_reg == '1 || phase_reg + 8'h01 == poll_div) ? '0
                                                                          : phase_reg + 8'h01;

    // One restoring step per cycle rebuilds the phase after an interval write.
    assign rem_shift = {rem_reg, poll_reg[bit_reg]};
    assign rem_sub   = rem_shift - {1'b0, poll_div};
    assign rem_step  = (rem_shift >= {1'b0, poll_div}) ? rem_sub[lmi_pkg::POLL_W-1:0]
                                                      : rem_shift[lmi_pkg::POLL_W-1:0];
    assign busy      = busy_reg;

    assign hist_wide  = {hist_reg, rec_good};
    assign hist_shift = hist_wide[HISTORY_BITS-1:0];

    lmi_link_check #(
        .HISTORY_BITS(HISTORY_BITS)
    ) u_link_check (
        .history        (hist_shift),
        .window_events  (cfg.window_events),
        .error_threshold(cfg.error_threshold),
        .reliable       (rel_new)
    );

    always_comb begin
        res           = '0;
        res.status    = lmi_pkg::ST_OK;
        res.send_kind = lmi_pkg::KIND_NONE;
        own_seq_next  = own_seq_reg;
        peer_seq_next = peer_seq_reg;
        poll_next     = poll_reg;
        phase_next    = phase_reg;
        await_next    = await_reg;
        rec_en        = 1'b0;
        rec_good      = 1'b0;
        bump          = 1'b0;

        case (evt.mode)
            lmi_pkg::MODE_POLL: begin
                if (cfg.role == lmi_pkg::ROLE_NETWORK) begin
                    res.status = lmi_pkg::ST_WRONG_ROLE;
                end else begin
                    res.tx_report_type = (phase_reg == '0) ? lmi_pkg::RPT_FULL
                                                           : lmi_pkg::RPT_LINK;
                    await_next       = res.tx_report_type[lmi_pkg::AWAIT_W-1:0];
                    res.send_kind    = lmi_pkg::KIND_ENQUIRY;
                    res.tx_has_verif = 1'b1;
                    res.tx_send_seq  = seq_inc;
                    res.tx_recv_seq  = peer_seq_reg;
                    own_seq_next     = seq_inc;
                    poll_next        = poll_reg + 8'h01;
                    phase_next       = phase_inc;
                end
            end
            lmi_pkg::MODE_TIMEOUT: begin
                bump   = 1'b1;
                rec_en = 1'b1;
            end
            lmi_pkg::MODE_ENQUIRY: begin
                if (cfg.role == lmi_pkg::ROLE_USER) begin
                    res.status = lmi_pkg::ST_WRONG_ROLE;
                end else if (!evt.report_present || !evt.verif_present) begin
                    res.status = lmi_pkg::ST_MISSING;
                end else begin
                    peer_seq_next      = evt.rx_send_seq;
                    rec_en             = 1'b1;
                    rec_good           = (evt.rx_recv_seq == own_seq_reg);
                    bump               = (evt.rx_recv_seq != own_seq_reg);
                    res.send_kind      = lmi_pkg::KIND_STATUS;
                    res.tx_report_type = evt.report_type;
                    if (evt.report_type <= lmi_pkg::RPT_LINK) begin
                        res.tx_has_verif = 1'b1;
                        res.tx_send_seq  = seq_inc;
                        res.tx_recv_seq  = evt.rx_send_seq;
                        own_seq_next     = seq_inc;
                    end
                end
            end
            lmi_pkg::MODE_STATUS: begin
                if (cfg.role == lmi_pkg::ROLE_NETWORK) begin
                    res.status = lmi_pkg::ST_WRONG_ROLE;
                end else if (!evt.report_present) begin
                    res.status = lmi_pkg::ST_MISSING;
                end else if (evt.report_type > lmi_pkg::RPT_LINK ||
                             evt.report_type != lmi_pkg::RPT_W'(await_reg)) begin
                    res.status = lmi_pkg::ST_BAD_REPORT;
                end else if (!evt.verif_present) begin
                    res.status = lmi_pkg::ST_MISSING;
                end else begin
                    peer_seq_next = evt.rx_send_seq;
                    if (evt.rx_recv_seq != own_seq_reg) begin
                        res.status = lmi_pkg::ST_SEQ_IGNORED;
                    end else begin
                        rec_en   = 1'b1;
                        rec_good = 1'b1;
                    end
                end
            end
            default: begin
                res.status = lmi_pkg::ST_OK;
            end
        endcase

        hist_next       = rec_en ? hist_shift : hist_reg;
        link_next       = rec_en ? rel_new : link_reg;
        err_next        = bump ? err_inc : err_reg;
        res.link_up     = link_next;
        res.error_total = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_seq_reg  <= '0;
            peer_seq_reg <= '0;
            hist_reg     <= '0;
            link_reg     <= 1'b0;
            err_reg      <= '0;
            poll_reg     <= '0;
            await_reg    <= '0;
        end else if (fire) begin
            own_seq_reg  <= own_seq_next;
            peer_seq_reg <= peer_seq_next;
            hist_reg     <= hist_next;
            link_reg     <= link_next;
            err_reg      <= err_next;
            poll_reg     <= poll_next;
            await_reg    <= await_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            busy_reg  <= 1'b0;
            bit_reg   <= BIT_W'(lmi_pkg::POLL_W - 1);
            rem_reg   <= '0;
        end else if (reload) begin
            busy_reg <= 1'b1;
            bit_reg  <= BIT_W'(lmi_pkg::POLL_W - 1);
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            bit_reg <= bit_reg - BIT_W'(1);
            if (bit_reg == '0) begin
                busy_reg  <= 1'b0;
                phase_reg <= rem_step;
            end
        end else if (fire) begin
            phase_reg <= phase_next;
        end
    end

    a_own_seq_skips_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && own_seq_reg != $past(own_seq_reg) |-> own_seq_reg != '0)
        else $error("own send sequence number advanced to zero");

    a_err_never_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> err_reg >= $past(err_reg))
        else $error("error counter decreased without reset");

    a_phase_below_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> phase_reg < poll_div)
        else $error("poll phase is not below the poll interval");

endmodule

// File: hdl/lmi_link_integrity_monitor.sv
`timescale 1ns / 1ps
// Top level of the LMI link integrity monitor: configuration registers,
// input beat register and result register. Uses lmi_pkg and lmi_event_core.
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tdata (event bytes), s_tuser (mode)
//   m_       out        m_tvalid/m_tready  m_tdata (result), m_tuser (send kind)
//   cfg_     in         cfg_valid/ready    cfg_index, cfg_data
//
// A beat waits in the input beat register while the core is busy or a result
// stalls, then goes through lmi_event_core to the result register; a new beat
// is accepted every cycle unless so held. A full poll interval write holds off
// beat processing and further register writes while the poll phase is rebuilt.
// Reset is synchronous, clears all protocol state and resets the configuration.
// A stalled result holds in the output register while one more beat waits.
module lmi_link_integrity_monitor #(
    parameter int HISTORY_BITS = lmi_pkg::HISTORY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // report_present, verif_present, report_type, rx_send_seq, rx_recv_seq
    input  logic [31:0]                    s_tdata,
    // mode
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, tx_report_type, tx_has_verif, tx_send_seq, tx_recv_seq,
    // link_up, error_total
    output logic [47:0]                    m_tdata,
    // send_kind
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lmi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmi_pkg::CFG_DATA_W-1:0] cfg_data
);

    lmi_pkg::cfg_t cfg_reg;
    lmi_pkg::evt_t in_evt_reg;
    lmi_pkg::evt_t in_evt;
    lmi_pkg::res_t core_res;
    lmi_pkg::res_t out_res_reg;
    logic          in_valid_reg;
    logic          out_valid_reg;
    logic          advance;
    logic          core_busy;
    logic          poll_reload;

    assign cfg_ready   = !core_busy;
    assign poll_reload = cfg_valid && cfg_ready &&
                         (lmi_pkg::cfg_idx_t'(cfg_index) == lmi_pkg::CFG_FULL_INT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.role               <= lmi_pkg::ROLE_RST;
            cfg_reg.full_poll_interval <= lmi_pkg::FULL_INT_RST;
            cfg_reg.error_threshold    <= lmi_pkg::THRESH_RST;
            cfg_reg.window_events      <= lmi_pkg::WINDOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (lmi_pkg::cfg_idx_t'(cfg_index))
                lmi_pkg::CFG_ROLE:      cfg_reg.role <= cfg_data[0];
                lmi_pkg::CFG_FULL_INT:  cfg_reg.full_poll_interval <= cfg_data;
                lmi_pkg::CFG_THRESHOLD: cfg_reg.error_threshold <= cfg_data[4:0];
                lmi_pkg::CFG_WINDOW:    cfg_reg.window_events <= cfg_data[4:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign in_evt.mode           = lmi_pkg::mode_t'(s_tuser);
    assign in_evt.report_present = s_tdata[0];
    assign in_evt.verif_present  = s_tdata[1];
    assign in_evt.report_type    = s_tdata[9:2];
    assign in_evt.rx_send_seq    = s_tdata[17:10];
    assign in_evt.rx_recv_seq    = s_tdata[25:18];

    assign advance  = in_valid_reg && !core_busy && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_evt_reg <= in_evt;
        end
    end

    lmi_event_core #(
        .HISTORY_BITS(HISTORY_BITS)
    ) u_event_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .evt    (in_evt_reg),
        .fire   (advance),
        .reload (poll_reload),
        .busy   (core_busy),
        .res    (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.send_kind;
    assign m_tdata  = {3'b000,
                       out_res_reg.error_total,
                       out_res_reg.link_up,
                       out_res_reg.tx_recv_seq,
                       out_res_reg.tx_send_seq,
                       out_res_reg.tx_has_verif,
                       out_res_reg.tx_report_type,
                       out_res_reg.status};

    a_beat_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(advance) |-> m_tvalid)
        else $error("processed beat did not reach the result register");

    a_no_send_no_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.send_kind == lmi_pkg::KIND_NONE
        |-> !out_res_reg.tx_has_verif && out_res_reg.tx_report_type == '0)
        else $error("result with nothing to send carries message fields");

    a_verif_has_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.tx_has_verif |-> out_res_reg.tx_send_seq != '0)
        else $error("verification element sent with zero send sequence");

endmodule
